### src/nfpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nfpp_pkg;

   // field and register widths
   localparam int FIELD_W  = 24;
   localparam int CELLS_W  = 4;
   localparam int CS_W     = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   // internal arithmetic widths
   localparam int COORD_W  = 26;
   localparam int DX_W     = 27;
   localparam int SQ_W     = 2 * DX_W - 1;
   localparam int D2_W     = 56;

   // defaults of the top level parameters
   localparam int MAX_FRAME_CELLS_DEFAULT  = 15;
   localparam int SAMPLES_PER_CELL_DEFAULT = 10;

   localparam int CELLS_REG_MAX = (1 << CELLS_W) - 1;
   localparam int CELL_SIZE_MAX = (1 << CS_W) - 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_COLS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_ROWS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CELL_SIZE  = 2'd2;

   // register reset values
   localparam logic [CELLS_W-1:0] FRAME_COLS_RESET = 4'd1;
   localparam logic [CELLS_W-1:0] FRAME_ROWS_RESET = 4'd1;
   localparam logic [CS_W-1:0]    CELL_SIZE_RESET  = 16'd256;

   // saturation limits
   localparam logic [FIELD_W-1:0]        U24_MAX = 24'hFF_FFFF;
   localparam logic signed [COORD_W-1:0] Q24_MAX = 26'sd8388607;
   localparam logic signed [COORD_W-1:0] Q24_MIN = -26'sd8388608;

   typedef struct packed {
      logic signed [FIELD_W-1:0] site_x;
      logic signed [FIELD_W-1:0] site_y;
      logic signed [FIELD_W-1:0] corner_x;
      logic signed [FIELD_W-1:0] corner_y;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] best_x;
      logic signed [FIELD_W-1:0] best_y;
      logic [FIELD_W-1:0]        best_distance;
   } rsp_type;

   typedef enum logic [1:0] {
      SIDE_TOP,
      SIDE_BOTTOM,
      SIDE_LEFT,
      SIDE_RIGHT
   } side_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_SIDE_INIT,
      ST_SWEEP,
      ST_DRAIN,
      ST_ROOT,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic     load;
      logic     prep;
      logic     side_init;
      logic     step;
      logic     root_start;
      side_type side;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic side_empty;
      logic k_last;
      logic pipe_busy;
      logic root_done;
   } status_type;

   // clamp a wide coordinate to the signed 24-bit range
   function automatic logic signed [FIELD_W-1:0] sat_coord(
      input logic signed [COORD_W-1:0] v);
      logic signed [COORD_W-1:0] c;
      begin
         c = v;
         if (v > Q24_MAX) c = Q24_MAX;
         if (v < Q24_MIN) c = Q24_MIN;
         sat_coord = c[FIELD_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

### src/nfpp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module nfpp_ctrl
   import nfpp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   output logic            rsp_valid,
   output cmd_type         cmd,
   input  wire status_type status
);

   state_type state_ff, state_in;
   side_type  side_ff, side_in;

   // state and side registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         side_ff  <= SIDE_TOP;
      end else begin
         state_ff <= state_in;
         side_ff  <= side_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      side_in        = side_ff;
      cmd            = '0;
      cmd.side       = side_ff;
      busy           = 1'b1;
      rsp_valid      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               side_in  = SIDE_TOP;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_SIDE_INIT;
         end
         ST_SIDE_INIT: begin
            cmd.side_init = 1'b1;
            if (!status.side_empty) begin
               state_in = ST_SWEEP;
            end else if (side_ff == SIDE_RIGHT) begin
               state_in = ST_DRAIN;
            end else begin
               side_in = side_type'(2'(side_ff) + 2'd1);
            end
         end
         ST_SWEEP: begin
            cmd.step = 1'b1;
            if (status.k_last) begin
               if (side_ff == SIDE_RIGHT) begin
                  state_in = ST_DRAIN;
               end else begin
                  side_in  = side_type'(2'(side_ff) + 2'd1);
                  state_in = ST_SIDE_INIT;
               end
            end
         end
         ST_DRAIN: begin
            // wait for the distance pipeline to settle the best sample
            if (!status.pipe_busy) begin
               cmd.root_start = 1'b1;
               state_in       = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (status.root_done) state_in = ST_DONE;
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### src/nfpp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module nfpp_datapath
   import nfpp_pkg::*;
#(
   parameter int MAX_FRAME_CELLS  = MAX_FRAME_CELLS_DEFAULT,
   parameter int SAMPLES_PER_CELL = SAMPLES_PER_CELL_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data,
   input  wire req_type               req_data,
   input  wire cmd_type               cmd,
   output status_type                 status,
   output rsp_type                    rsp_data
);

   localparam int CELLS_CAP = (MAX_FRAME_CELLS < CELLS_REG_MAX) ?
                              MAX_FRAME_CELLS : CELLS_REG_MAX;
   localparam int HALF_STEPS = SAMPLES_PER_CELL / 2;
   localparam int K_W   = $clog2(CELLS_CAP * SAMPLES_PER_CELL);
   localparam int OFF_W = $clog2(CELLS_CAP * CELL_SIZE_MAX + 1);
   localparam int REM_W = $clog2(SAMPLES_PER_CELL);
   // reciprocal for cell_size / SAMPLES_PER_CELL, exact over 16-bit inputs
   localparam int RECIP_SH = CS_W + $clog2(SAMPLES_PER_CELL);
   localparam int RECIP_W  = CS_W + 1;
   localparam int PROD_W   = RECIP_SH + CS_W;
   localparam longint unsigned RECIP =
      ((64'd1 << RECIP_SH) + SAMPLES_PER_CELL - 1) / SAMPLES_PER_CELL;
   localparam logic [RECIP_W-1:0] RECIP_VAL = RECIP_W'(RECIP);
   localparam logic [REM_W:0]     SPC_VAL   = (REM_W + 1)'(SAMPLES_PER_CELL);
   localparam logic [K_W-1:0]     HALF_VAL  = K_W'(HALF_STEPS);

   // configuration registers
   logic [CELLS_W-1:0] cols_ff, rows_ff;
   logic [CS_W-1:0]    cs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= FRAME_COLS_RESET;
         rows_ff <= FRAME_ROWS_RESET;
         cs_ff   <= CELL_SIZE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_FRAME_COLS: cols_ff <= csr_write_data[CELLS_W-1:0];
            REG_FRAME_ROWS: rows_ff <= csr_write_data[CELLS_W-1:0];
            REG_CELL_SIZE:  cs_ff   <= csr_write_data[CS_W-1:0];
            default: ;
         endcase
      end
   end

   // job operands and per-job constants
   logic signed [FIELD_W-1:0] sx_ff, sy_ff, cx_ff, cy_ff;
   logic [CS_W-1:0]           q0_ff;
   logic [REM_W-1:0]          r0_ff;
   logic [CELLS_W-1:0]        hcells_ff, vcells_ff;
   logic [K_W-1:0]            hlast_ff, vlast_ff;
   logic signed [COORD_W-1:0] bottom_y_ff, right_x_ff;

   logic [PROD_W-1:0]         recip_prod;
   logic [CS_W-1:0]           q0_times, r0_full;
   logic [CELLS_W-1:0]        hcells, vcells;
   logic [CS_W+CELLS_W-1:0]   hspan, vspan;

   assign recip_prod = PROD_W'(cs_ff) * PROD_W'(RECIP_VAL);
   assign q0_times   = CS_W'(q0_ff * SAMPLES_PER_CELL);
   assign r0_full    = cs_ff - q0_times;
   assign hcells     = (cols_ff > CELLS_W'(CELLS_CAP)) ? CELLS_W'(CELLS_CAP) : cols_ff;
   assign vcells     = (rows_ff > CELLS_W'(CELLS_CAP)) ? CELLS_W'(CELLS_CAP) : rows_ff;
   assign hspan      = hcells * cs_ff;
   assign vspan      = vcells * cs_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sx_ff <= req_data.site_x;
         sy_ff <= req_data.site_y;
         cx_ff <= req_data.corner_x;
         cy_ff <= req_data.corner_y;
         q0_ff <= recip_prod[RECIP_SH +: CS_W];
      end
      if (cmd.prep) begin
         r0_ff       <= r0_full[REM_W-1:0];
         hcells_ff   <= hcells;
         vcells_ff   <= vcells;
         hlast_ff    <= K_W'(int'(hcells) * SAMPLES_PER_CELL - HALF_STEPS);
         vlast_ff    <= K_W'(int'(vcells) * SAMPLES_PER_CELL - HALF_STEPS);
         bottom_y_ff <= COORD_W'(cy_ff) - COORD_W'(vspan);
         right_x_ff  <= COORD_W'(cx_ff) + COORD_W'(hspan);
      end
   end

   // step counter and offset k * cell_size / SAMPLES_PER_CELL, kept as
   // quotient and remainder
   logic [K_W-1:0]   k_ff;
   logic [OFF_W-1:0] off_ff;
   logic [REM_W-1:0] rem_ff;
   logic [REM_W:0]   rem_sum;
   logic             rem_carry;
   logic [REM_W:0]   rem_next;

   assign rem_sum   = {1'b0, rem_ff} + {1'b0, r0_ff};
   assign rem_carry = (rem_sum >= SPC_VAL);
   assign rem_next  = rem_carry ? (rem_sum - SPC_VAL) : rem_sum;

   always_ff @(posedge clock) begin
      if (cmd.side_init) begin
         k_ff   <= '0;
         off_ff <= '0;
         rem_ff <= '0;
      end else if (cmd.step) begin
         k_ff   <= k_ff + K_W'(1);
         off_ff <= off_ff + OFF_W'(q0_ff) + OFF_W'(rem_carry);
         rem_ff <= rem_next[REM_W-1:0];
      end
   end

   // sample position on the current side
   logic signed [COORD_W-1:0] off_c, px_c, py_c;
   assign off_c = COORD_W'(off_ff);

   always_comb begin
      case (cmd.side)
         SIDE_TOP: begin
            px_c = COORD_W'(cx_ff) + off_c;
            py_c = COORD_W'(cy_ff);
         end
         SIDE_BOTTOM: begin
            px_c = COORD_W'(cx_ff) + off_c;
            py_c = bottom_y_ff;
         end
         SIDE_LEFT: begin
            px_c = COORD_W'(cx_ff);
            py_c = COORD_W'(cy_ff) - off_c;
         end
         SIDE_RIGHT: begin
            px_c = right_x_ff;
            py_c = COORD_W'(cy_ff) - off_c;
         end
         default: begin
            px_c = '0;
            py_c = '0;
         end
      endcase
   end

   // stage a: sample point, skipping the half cell at each corner
   logic                      a_vld_ff;
   logic signed [COORD_W-1:0] a_px_ff, a_py_ff;

   always_ff @(posedge clock) begin
      if (reset) a_vld_ff <= 1'b0;
      else       a_vld_ff <= cmd.step && (k_ff >= HALF_VAL);
      a_px_ff <= px_c;
      a_py_ff <= py_c;
   end

   // stage b: squared offsets
   logic signed [DX_W-1:0]   dx, dy;
   logic signed [2*DX_W-1:0] sqx, sqy;
   logic                      b_vld_ff;
   logic signed [COORD_W-1:0] b_px_ff, b_py_ff;
   logic [SQ_W-1:0]           b_sqx_ff, b_sqy_ff;

   assign dx  = DX_W'(a_px_ff) - DX_W'(sx_ff);
   assign dy  = DX_W'(a_py_ff) - DX_W'(sy_ff);
   assign sqx = dx * dx;
   assign sqy = dy * dy;

   always_ff @(posedge clock) begin
      if (reset) b_vld_ff <= 1'b0;
      else       b_vld_ff <= a_vld_ff;
      b_px_ff  <= a_px_ff;
      b_py_ff  <= a_py_ff;
      b_sqx_ff <= sqx[SQ_W-1:0];
      b_sqy_ff <= sqy[SQ_W-1:0];
   end

   // stage c: keep the first nearest sample
   logic [D2_W-1:0]           d2;
   logic                      have_best_ff;
   logic [D2_W-1:0]           best_d2_ff;
   logic signed [COORD_W-1:0] best_px_ff, best_py_ff;

   assign d2 = D2_W'(b_sqx_ff) + D2_W'(b_sqy_ff);

   always_ff @(posedge clock) begin
      if (reset || cmd.prep) begin
         have_best_ff <= 1'b0;
      end else if (b_vld_ff && (!have_best_ff || d2 < best_d2_ff)) begin
         have_best_ff <= 1'b1;
      end
      if (b_vld_ff && (!have_best_ff || d2 < best_d2_ff)) begin
         best_d2_ff <= d2;
         best_px_ff <= b_px_ff;
         best_py_ff <= b_py_ff;
      end
   end

   // floor square root, two radicand bits per cycle
   logic [D2_W-1:0] n_ff, res_ff, bit_ff;
   logic [D2_W-1:0] trial;
   assign trial = res_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (cmd.root_start) begin
         n_ff   <= best_d2_ff;
         res_ff <= '0;
         bit_ff <= D2_W'(1) << (D2_W - 2);
      end else if (bit_ff != '0) begin
         if (n_ff >= trial) begin
            n_ff   <= n_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   // status
   always_comb begin
      status = '0;
      if (cmd.side == SIDE_TOP || cmd.side == SIDE_BOTTOM) begin
         status.side_empty = (hcells_ff == '0);
         status.k_last     = (k_ff == hlast_ff);
      end else begin
         status.side_empty = (vcells_ff == '0);
         status.k_last     = (k_ff == vlast_ff);
      end
      status.pipe_busy = a_vld_ff | b_vld_ff;
      status.root_done = (bit_ff == '0);
   end

   // result word, saturated
   always_comb begin
      if (have_best_ff) begin
         rsp_data.best_x = sat_coord(best_px_ff);
         rsp_data.best_y = sat_coord(best_py_ff);
         rsp_data.best_distance = (res_ff > D2_W'(U24_MAX)) ?
                                  U24_MAX : res_ff[FIELD_W-1:0];
      end else begin
         rsp_data.best_x        = '0;
         rsp_data.best_y        = '0;
         rsp_data.best_distance = U24_MAX;
      end
   end

endmodule

`default_nettype wire

### src/nearest_frame_perimeter_point_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Nearest frame perimeter point. A word is taken when start is high and busy
// is low; the block then walks the frame perimeter one sample per cycle (top,
// bottom, left, right sides, with a setup state per side), feeds each sample
// through a three-stage squared-distance pipeline, and finishes with a
// shift-subtract square root on the best squared distance. rsp_valid is high
// for exactly one cycle with rsp_data and cannot be held off, so the receiver
// must capture it then; busy falls in the following cycle. Configuration is
// written through the csr_ port; the user must write it only while busy is
// low, as the block itself does not enforce this.

module nearest_frame_perimeter_point_unit
   import nfpp_pkg::*;
#(
   parameter int MAX_FRAME_CELLS  = MAX_FRAME_CELLS_DEFAULT,
   parameter int SAMPLES_PER_CELL = SAMPLES_PER_CELL_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   cmd_type    cmd;
   status_type status;

   // sequencing
   nfpp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   // sample generation, distance pipeline and square root
   nfpp_datapath #(
      .MAX_FRAME_CELLS  (MAX_FRAME_CELLS),
      .SAMPLES_PER_CELL (SAMPLES_PER_CELL)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_data         (req_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_data         (rsp_data)
   );

endmodule

`default_nettype wire

### src/nfpp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module nfpp_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid
);

   // a result only comes out of a running job
   a_rsp_in_job: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   // a result strobe lasts one cycle
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // the block goes idle right after its result
   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("still busy after result");

   // an accepted word starts a job that has no result in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted word did not start a job");

endmodule

bind nearest_frame_perimeter_point_unit nfpp_checker u_nfpp_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

`default_nettype wire
